@@ src/mqttrx_pkg.sv @@
// ---------------------------------------------------------------------------
// mqttrx_pkg
// Types and constants shared by the MQTT receive deframer modules.
// ---------------------------------------------------------------------------
package mqttrx_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_TOPIC   = 2'd1,
        KIND_PAYLOAD = 2'd2
    } byte_kind_t;

    localparam logic [3:0] TYPE_CONNACK  = 4'h2;
    localparam logic [3:0] TYPE_PUBLISH  = 4'h3;
    localparam logic [3:0] TYPE_PINGRESP = 4'hD;

    localparam logic [7:0] TYPE_MASK     = 8'hF0;
    localparam logic [7:0] QOS_MASK      = 8'h06;
    localparam logic [7:0] LEN_MASK      = 8'h7F;
    localparam logic [7:0] LEN_CONT      = 8'h80;

    localparam int         LEN_BYTES_MAX = 4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       session_open;
    } in_item_t;

    typedef struct packed {
        byte_kind_t  byte_kind;
        logic [7:0]  data_byte;
        logic        packet_end;
        logic [3:0]  packet_type;
        logic [1:0]  qos_level;
        logic [15:0] message_id;
        logic        ack_needed;
        logic        connack_accepted;
        logic        ping_response;
        logic        topic_truncated;
    } result_t;

endpackage

@@ src/mqttrx_in_stage.sv @@
// ---------------------------------------------------------------------------
// mqttrx_in_stage
// Input register: holds one received transaction until the parser takes it.
// ---------------------------------------------------------------------------
module mqttrx_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  mqttrx_pkg::in_item_t s_item,
    input  logic                advance,
    output logic                item_valid,
    output mqttrx_pkg::in_item_t item
);
    import mqttrx_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;

    assign s_ready    = !vld_reg || advance;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_ready)
        begin
            vld_next = s_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg <= s_item;
        end
    end

endmodule

@@ src/mqttrx_parser.sv @@
// ---------------------------------------------------------------------------
// mqttrx_parser
// Packet state and the per-byte decode of fixed header, length and body.
// ---------------------------------------------------------------------------
module mqttrx_parser #(
    parameter int MAX_TOPIC_BYTES = 63
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  mqttrx_pkg::in_item_t item,
    output logic                 produce,
    output mqttrx_pkg::result_t  result
);
    import mqttrx_pkg::*;

    localparam logic [15:0] MaxTopic = 16'(MAX_TOPIC_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_TLEN    = 3'd2,
        PH_TOPIC   = 3'd3,
        PH_MSGID   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_OTHER   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  type_reg, type_next;
    logic [1:0]  qos_reg, qos_next;
    logic [27:0] rl_reg, rl_next;
    logic [2:0]  lcnt_reg, lcnt_next;
    logic [27:0] bc_reg, bc_next;
    logic [15:0] tl_reg, tl_next;
    logic [15:0] tseen_reg, tseen_next;
    logic [15:0] id_reg, id_next;
    logic [7:0]  conn_reg, conn_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [27:0] len_bits;
        logic [28:0] consumed;
        logic [29:0] need_id;
        logic        id_follows;
        phase_t      after_topic;
        logic        pkt_end;
        byte_kind_t  kind;
        logic        id_ok;

        b           = item.rx_byte;
        phase_next  = phase_reg;
        type_next   = type_reg;
        qos_next    = qos_reg;
        rl_next     = rl_reg;
        lcnt_next   = lcnt_reg;
        bc_next     = bc_reg;
        tl_next     = tl_reg;
        tseen_next  = tseen_reg;
        id_next     = id_reg;
        conn_next   = conn_reg;
        pkt_end     = 1'b0;
        kind        = KIND_HEADER;
        len_bits    = '0;

        // a topic is followed by a message id only if two body bytes remain
        consumed    = {1'b0, bc_reg} + 29'd1;
        need_id     = {1'b0, consumed} + 30'd2;
        id_follows  = (qos_reg != 2'd0) && ({2'b0, rl_reg} >= need_id);
        after_topic = id_follows ? PH_MSGID : PH_PAYLOAD;

        unique case (lcnt_reg[1:0])
            2'd0: len_bits = {21'd0, b[6:0] & LEN_MASK[6:0]};
            2'd1: len_bits = {14'd0, b[6:0], 7'd0};
            2'd2: len_bits = {7'd0, b[6:0], 14'd0};
            2'd3: len_bits = {b[6:0], 21'd0};
            default: len_bits = '0;
        endcase

        if (!item.session_open)
        begin
            phase_next = PH_IDLE;
            type_next  = '0;
            qos_next   = '0;
            rl_next    = '0;
            lcnt_next  = '0;
            bc_next    = '0;
            tl_next    = '0;
            tseen_next = '0;
            id_next    = '0;
            conn_next  = '0;
        end
        else if (phase_reg == PH_IDLE)
        begin
            type_next  = 4'((b & TYPE_MASK) >> 4);
            qos_next   = 2'((b & QOS_MASK) >> 1);
            rl_next    = '0;
            lcnt_next  = '0;
            bc_next    = '0;
            tl_next    = '0;
            tseen_next = '0;
            id_next    = '0;
            conn_next  = '0;
            phase_next = PH_LEN;
        end
        else if (phase_reg == PH_LEN)
        begin
            rl_next   = rl_reg | len_bits;
            lcnt_next = lcnt_reg + 3'd1;
            if ((b & LEN_CONT) == 8'd0 || lcnt_next >= 3'(LEN_BYTES_MAX))
            begin
                if (rl_next == 28'd0)
                begin
                    pkt_end    = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = (type_reg == TYPE_PUBLISH) ? PH_TLEN : PH_OTHER;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TLEN:
                begin
                    tl_next = {tl_reg[7:0], b};
                    if (bc_reg != 28'd0)
                    begin
                        phase_next = (tl_next != 16'd0) ? PH_TOPIC : after_topic;
                    end
                end
                PH_TOPIC:
                begin
                    if (tseen_reg < MaxTopic)
                    begin
                        kind = KIND_TOPIC;
                    end
                    tseen_next = tseen_reg + 16'd1;
                    if (tseen_next >= tl_reg)
                    begin
                        phase_next = after_topic;
                    end
                end
                PH_MSGID:
                begin
                    id_next = {id_reg[7:0], b};
                    if (bc_reg >= {11'd0, {1'b0, tl_reg} + 17'd3})
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    kind = KIND_PAYLOAD;
                end
                default:
                begin
                    if (bc_reg == 28'd1)
                    begin
                        conn_next = b;
                    end
                end
            endcase
            bc_next = consumed[27:0];
            if (consumed >= {1'b0, rl_reg})
            begin
                pkt_end    = 1'b1;
                phase_next = PH_IDLE;
            end
        end

        id_ok = (type_next == TYPE_PUBLISH) && (qos_next != 2'd0)
                && (rl_next >= {11'd0, {1'b0, tl_next} + 17'd4});

        produce                 = item.session_open;
        result.byte_kind        = kind;
        result.data_byte        = b;
        result.packet_end       = pkt_end;
        result.packet_type      = type_next;
        result.qos_level        = qos_next;
        result.message_id       = (pkt_end && id_ok) ? id_next : 16'd0;
        result.ack_needed       = pkt_end && id_ok;
        result.connack_accepted = pkt_end && (type_next == TYPE_CONNACK)
                                  && (rl_next >= 28'd2) && (conn_next == 8'd0);
        result.ping_response    = pkt_end && (type_next == TYPE_PINGRESP);
        result.topic_truncated  = pkt_end && (tseen_next > MaxTopic);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            type_reg  <= '0;
            qos_reg   <= '0;
            rl_reg    <= '0;
            lcnt_reg  <= '0;
            bc_reg    <= '0;
            tl_reg    <= '0;
            tseen_reg <= '0;
            id_reg    <= '0;
            conn_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            qos_reg   <= qos_next;
            rl_reg    <= rl_next;
            lcnt_reg  <= lcnt_next;
            bc_reg    <= bc_next;
            tl_reg    <= tl_next;
            tseen_reg <= tseen_next;
            id_reg    <= id_next;
            conn_reg  <= conn_next;
        end
    end

endmodule

@@ src/mqttrx_out_stage.sv @@
// ---------------------------------------------------------------------------
// mqttrx_out_stage
// Result register: holds one decoded byte until the sink takes it.
// ---------------------------------------------------------------------------
module mqttrx_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    input  mqttrx_pkg::result_t load_result,
    output logic                open,
    output logic                m_valid,
    input  logic                m_ready,
    output mqttrx_pkg::result_t m_result
);
    import mqttrx_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign open     = !vld_reg || m_ready;
    assign m_valid  = vld_reg;
    assign m_result = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (open)
        begin
            vld_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (open && load_valid)
        begin
            res_reg <= load_result;
        end
    end

endmodule

@@ src/mqtt_rx_packet_deframer_top.sv @@
// ---------------------------------------------------------------------------
// mqtt_rx_packet_deframer_top
// MQTT receive deframer: splits a client's byte stream into tagged packets.
// ---------------------------------------------------------------------------
// Takes one received stream byte per transaction and returns one tagged byte
// per transaction while tuser says the session is open; a byte taken with the
// session closed returns nothing and returns the parser to its reset state.
// Throughput is one byte per clock cycle while m_axis_tready does not stall
// the output: the byte is registered, decoded combinationally against the
// packet state (that state update is the loop that sets the rate) and
// registered again at the output. The message id and flags of a packet appear
// only on the transaction that carries tlast.
module mqtt_rx_packet_deframer_top #(
    parameter int MAX_TOPIC_BYTES = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // session_open
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte, packet_type, qos_level, message_id, ack_needed,
    // connack_accepted, ping_response, topic_truncated, zero fill
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // byte_kind
    output logic        m_axis_tlast    // packet_end
);
    import mqttrx_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_open;
    logic     fire;
    logic     produce;
    result_t  result;
    result_t  m_result;

    assign s_item.rx_byte      = s_axis_tdata;
    assign s_item.session_open = s_axis_tuser;
    assign fire                = item_valid && out_open;

    mqttrx_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (out_open),
        .item_valid (item_valid),
        .item       (item)
    );

    mqttrx_parser #(
        .MAX_TOPIC_BYTES (MAX_TOPIC_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item),
        .produce (produce),
        .result  (result)
    );

    mqttrx_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (fire && produce),
        .load_result (result),
        .open        (out_open),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_result    (m_result)
    );

    assign m_axis_tdata = {6'd0,
                           m_result.topic_truncated,
                           m_result.ping_response,
                           m_result.connack_accepted,
                           m_result.ack_needed,
                           m_result.message_id,
                           m_result.qos_level,
                           m_result.packet_type,
                           m_result.data_byte};
    assign m_axis_tuser = m_result.byte_kind;
    assign m_axis_tlast = m_result.packet_end;

    // per-packet summary only on the closing byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tdata[33:30] == 4'd0 && m_axis_tdata[29:14] == 16'd0)
        else $error("summary fields set before end of packet");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[30] |->
            m_axis_tdata[11:8] == TYPE_PUBLISH && m_axis_tdata[13:12] != 2'd0)
        else $error("ack owed for a packet that is not a QoS PUBLISH");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_TOPIC || m_axis_tuser == KIND_PAYLOAD) |->
            m_axis_tdata[11:8] == TYPE_PUBLISH)
        else $error("topic or payload byte outside a PUBLISH");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.session_open |=> !m_axis_tvalid)
        else $error("result produced for a byte taken with the session closed");

endmodule
